### hw/rtl/csc_pkg.sv
`default_nettype none

package csc_pkg;

  // Fixed field and datapath widths.
  localparam int VALUE_WIDTH = 16;
  localparam int ACC_WIDTH   = 48;
  localparam int DIV_NW      = 60;
  localparam int DIV_DW      = 25;

  // Fixed-point constants of the exponential.
  localparam logic [16:0] LOG2E_Q16    = 17'd94548;
  localparam logic [14:0] LN2_Q31_STEP = 15'd22713;
  localparam logic [31:0] ONE_Q31      = 32'h8000_0000;
  localparam logic [30:0] LOGIT_LIMIT  = 31'h7FFF_FFFF;

  // Configuration register indexes.
  localparam logic CFG_CLASS_COUNT = 1'b0;
  localparam logic CFG_COS_SCALE   = 1'b1;

  typedef struct packed {
    logic                          mode;
    logic [5:0]                    class_index;
    logic [9:0]                    element_index;
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          last;
  } request_t;

  typedef struct packed {
    logic [5:0]  best_class;
    logic [15:0] confidence;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC,
    ST_SQRT,
    ST_NORM,
    ST_ZDIV,
    ST_LRD,
    ST_LMUL,
    ST_LDIV,
    ST_ERD,
    ST_ET,
    ST_EFRAC,
    ST_ELOW,
    ST_ESUM,
    ST_CSTART,
    ST_CDIV,
    ST_FINISH
  } state_t;

  // Q31 factors 2^-(2^-(j+1)) for the fraction bits of the exponent.
  function automatic logic [31:0] pow2_frac(input logic [2:0] j);
    logic [31:0] r;
    case (j)
      3'd0:    r = 32'd1518500250;
      3'd1:    r = 32'd1805811301;
      3'd2:    r = 32'd1969251188;
      3'd3:    r = 32'd2056437387;
      3'd4:    r = 32'd2101467502;
      3'd5:    r = 32'd2124350982;
      3'd6:    r = 32'd2135885998;
      3'd7:    r = 32'd2141676973;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/csc_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module csc_div (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  input  wire [csc_pkg::DIV_NW-1:0]    num,
  input  wire [csc_pkg::DIV_DW-1:0]    den,
  output logic                         done,
  output logic [csc_pkg::DIV_NW-1:0]   quot
);
  import csc_pkg::*;

  logic [DIV_DW-1:0] rem;
  logic [DIV_DW-1:0] den_q;
  logic [DIV_NW-1:0] work;
  logic [5:0]        cnt;
  logic              running;
  logic [DIV_DW:0]   rem_sh;
  logic              ge;

  assign rem_sh = {rem, work[DIV_NW-1]};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign quot   = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
      end else if (running && cnt == 6'(DIV_NW - 1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work  <= num;
      den_q <= den;
      rem   <= '0;
      cnt   <= '0;
    end else if (running) begin
      rem  <= ge ? DIV_DW'(rem_sh - {1'b0, den_q}) : rem_sh[DIV_DW-1:0];
      work <= {work[DIV_NW-2:0], ge};
      cnt  <= cnt + 6'd1;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/cosine_softmax_classifier_top.sv
`default_nettype none

// Cosine-similarity softmax classification head.
// Requests enter on the request port when start is high and busy is low.
// A request with mode 0 writes one class embedding element into the table.
// A request with mode 1 streams one image element: it is multiplied with that
// element of every class row in a single shared multiply-accumulate pipe.
// The sum of squares is updated as the request is taken.
// When the image element carries last, the block then runs a square root,
// one divide on the shared divider per class logit, an exponential per
// class, and a final divide for the confidence; with a zero norm, the
// confidence is 65536 divided by the scored class count instead. The result
// appears on result with done high for exactly one cycle; the receiver
// cannot stall it, so the next request may be taken in that same cycle.
// Configuration writes use cfg_write, cfg_index and cfg_data and take effect at
// once; the user must issue them only while the block is idle (not enforced).
// Reset sets class_count to 1 and cos_scale to 100 and clears all
// accumulators; the class table holds no defined value until written.
module cosine_softmax_classifier_top #(
  parameter int MAX_CLASSES = 64,
  parameter int MAX_DIM     = 1024
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                start,
  input  csc_pkg::request_t  request,
  output logic               busy,
  output logic               done,
  output csc_pkg::result_t   result,
  input  wire                cfg_write,
  input  wire [0:0]          cfg_index,
  input  wire [7:0]          cfg_data
);
  import csc_pkg::*;

  localparam int CNW    = $clog2(MAX_CLASSES + 1);
  localparam int CIW    = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int TDEPTH = MAX_CLASSES * MAX_DIM;
  localparam int TAW    = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;

  state_t state, state_next;

  // Configuration registers.
  logic [6:0] class_count;
  logic [7:0] cos_scale;
  logic [CNW-1:0] used;

  // Latched image element and the global counter.
  logic signed [VALUE_WIDTH-1:0] v_q;
  logic [9:0]     ei_q;
  logic           last_q;
  logic [CNW-1:0] cnt;
  logic [CIW-1:0] idx;

  // Stores.
  logic signed [VALUE_WIDTH-1:0] table_mem [TDEPTH];
  logic signed [VALUE_WIDTH-1:0] tbl_rd;
  logic [ACC_WIDTH-1:0] acc_mem [MAX_CLASSES];
  logic [ACC_WIDTH-1:0] acc_rd;
  logic [MAX_CLASSES-1:0] acc_valid;
  logic           acc_vld_rd;
  logic signed [31:0] logit_mem [MAX_CLASSES];
  logic signed [31:0] logit_rd;
  logic [ACC_WIDTH-1:0] square_sum;

  // Multiply-accumulate pipe.
  logic p1v, p2v;
  logic [CIW-1:0] idx1, idx2;
  logic signed [31:0] prod2;
  logic [ACC_WIDTH-1:0] acc2;

  // Square root.
  logic [47:0] sq_src;
  logic [25:0] sq_rem;
  logic [23:0] sq_res;
  logic [4:0]  sq_cnt;
  logic [27:0] rem_sh, trial;
  logic        sq_ge;

  // Logits and exponential.
  logic [ACC_WIDTH-1:0] acc_val, mag;
  logic [59:0] lnum;
  logic        neg_q;
  logic [30:0] qsat;
  logic signed [31:0] logit_new;
  logic signed [31:0] mx;
  logic [CIW-1:0] best;
  logic [31:0] dd;
  logic [48:0] tprod;
  logic        big_q;
  logic [4:0]  nsh_q;
  logic [15:0] f_q;
  logic [31:0] lowf, m, mul_b;
  logic [63:0] mprod;
  logic [2:0]  j_q;
  logic [16:0] term;
  logic [24:0] sum;
  logic [15:0] conf_q;

  // Shared divider.
  logic              div_start, div_done;
  logic [DIV_NW-1:0] div_num, div_quot;
  logic [DIV_DW-1:0] div_den;

  logic accept, in_load, in_elem, last_cls;

  csc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign busy    = state != ST_IDLE;
  assign accept  = start && !busy;
  assign in_load = (32'(request.class_index) < MAX_CLASSES) &&
                   (32'(request.element_index) < MAX_DIM);
  assign in_elem = 32'(request.element_index) < MAX_DIM;
  assign idx     = cnt[CIW-1:0];

  // A class count of zero scores one class; a count above the table scores all.
  always_comb begin
    if (class_count == 7'd0) begin
      used = CNW'(1);
    end else if (32'(class_count) > MAX_CLASSES) begin
      used = CNW'(MAX_CLASSES);
    end else begin
      used = CNW'(class_count);
    end
  end
  assign last_cls = cnt == used - CNW'(1);

  // Square root step: two radicand bits per cycle.
  assign rem_sh = {sq_rem, sq_src[47:46]};
  assign trial  = {2'b00, sq_res, 2'b01};
  assign sq_ge  = rem_sh >= trial;

  // Logit numerator: magnitude of the dot product times 16 * cos_scale.
  assign acc_val = acc_vld_rd ? acc_rd : '0;
  assign mag     = acc_val[ACC_WIDTH-1] ? (~acc_val + 48'd1) : acc_val;
  assign lnum    = 60'(mag) * 60'({cos_scale, 4'b0000});
  assign qsat    = (|div_quot[DIV_NW-1:31]) ? LOGIT_LIMIT : div_quot[30:0];
  assign logit_new = neg_q ? -$signed({1'b0, qsat}) : $signed({1'b0, qsat});

  // Exponent: t = d * log2(e), split into integer shift and fraction.
  // The gap to the maximum is never negative and fits in 32 unsigned bits.
  assign dd    = mx - logit_rd;
  assign tprod = 49'(dd) * 49'(LOG2E_Q16);
  assign mul_b = (state == ST_ELOW) ? lowf : pow2_frac(j_q);
  assign mprod = 64'(m) * 64'(mul_b);
  assign term  = big_q ? 17'd0 : (17'(m >> 15) >> nsh_q);

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    case (state)
      ST_IDLE: begin
        if (accept && request.mode) begin
          if (in_elem) begin
            state_next = ST_MAC;
          end else if (request.last) begin
            state_next = ST_SQRT;
          end
        end
      end
      ST_MAC: begin
        if (cnt == CNW'(MAX_CLASSES) && !p1v && !p2v) begin
          state_next = last_q ? ST_SQRT : ST_IDLE;
        end
      end
      ST_SQRT: begin
        if (sq_cnt == 5'd23) begin
          state_next = ST_NORM;
        end
      end
      ST_NORM: begin
        if (sq_res == 24'd0) begin
          div_start  = 1'b1;
          div_num    = DIV_NW'(65536);
          div_den    = DIV_DW'(used);
          state_next = ST_ZDIV;
        end else begin
          state_next = ST_LRD;
        end
      end
      ST_ZDIV: begin
        if (div_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_LRD: begin
        state_next = ST_LMUL;
      end
      ST_LMUL: begin
        div_start  = 1'b1;
        div_num    = lnum;
        div_den    = DIV_DW'(sq_res);
        state_next = ST_LDIV;
      end
      ST_LDIV: begin
        if (div_done) begin
          state_next = last_cls ? ST_ERD : ST_LRD;
        end
      end
      ST_ERD: begin
        state_next = ST_ET;
      end
      ST_ET: begin
        state_next = ST_EFRAC;
      end
      ST_EFRAC: begin
        if (j_q == 3'd7) begin
          state_next = ST_ELOW;
        end
      end
      ST_ELOW: begin
        state_next = ST_ESUM;
      end
      ST_ESUM: begin
        state_next = last_cls ? ST_CSTART : ST_ERD;
      end
      ST_CSTART: begin
        div_start  = 1'b1;
        div_num    = DIV_NW'(1) << 32;
        div_den    = sum;
        state_next = ST_CDIV;
      end
      ST_CDIV: begin
        if (div_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      class_count <= 7'd1;
      cos_scale   <= 8'd100;
      done        <= 1'b0;
      square_sum  <= '0;
      acc_valid   <= '0;
      p1v         <= 1'b0;
      p2v         <= 1'b0;
    end else begin
      state <= state_next;
      done  <= state == ST_FINISH;
      if (cfg_write) begin
        case (cfg_index)
          CFG_CLASS_COUNT: class_count <= cfg_data[6:0];
          CFG_COS_SCALE:   cos_scale   <= cfg_data;
          default: ;
        endcase
      end
      if (accept && request.mode && in_elem) begin
        square_sum <= square_sum + 48'(32'(request.value * request.value));
      end
      p1v <= (state == ST_MAC) && (cnt != CNW'(MAX_CLASSES));
      p2v <= p1v;
      if (state == ST_FINISH) begin
        acc_valid  <= '0;
        square_sum <= '0;
      end else if (p2v) begin
        acc_valid[idx2] <= 1'b1;
      end
    end
  end

  // Memories.
  always_ff @(posedge clk) begin
    if (accept && !request.mode && in_load) begin
      table_mem[TAW'(request.class_index) * TAW'(MAX_DIM) + TAW'(request.element_index)]
        <= request.value;
    end
    tbl_rd     <= table_mem[TAW'(idx) * TAW'(MAX_DIM) + TAW'(ei_q)];
    acc_rd     <= acc_mem[idx];
    acc_vld_rd <= acc_valid[idx];
    if (p2v) begin
      acc_mem[idx2] <= acc2 + {{16{prod2[31]}}, prod2};
    end
    logit_rd <= logit_mem[idx];
    if (state == ST_LDIV && div_done) begin
      logit_mem[idx] <= logit_new;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    idx1  <= idx;
    idx2  <= idx1;
    prod2 <= 32'(v_q * tbl_rd);
    acc2  <= acc_vld_rd ? acc_rd : '0;

    if (state == ST_IDLE || state == ST_MAC) begin
      sq_src <= square_sum;
      sq_rem <= '0;
      sq_res <= '0;
      sq_cnt <= '0;
    end else if (state == ST_SQRT) begin
      sq_src <= {sq_src[45:0], 2'b00};
      sq_rem <= sq_ge ? 26'(rem_sh - trial) : rem_sh[25:0];
      sq_res <= {sq_res[22:0], sq_ge};
      sq_cnt <= sq_cnt + 5'd1;
    end

    case (state)
      ST_IDLE: begin
        cnt <= '0;
        if (accept) begin
          v_q    <= request.value;
          ei_q   <= request.element_index;
          last_q <= request.last;
        end
      end
      ST_MAC: begin
        if (cnt != CNW'(MAX_CLASSES)) begin
          cnt <= cnt + CNW'(1);
        end
      end
      ST_NORM: begin
        cnt  <= '0;
        best <= '0;
        sum  <= '0;
      end
      ST_ZDIV: begin
        conf_q <= (|div_quot[DIV_NW-1:16]) ? 16'hFFFF : div_quot[15:0];
      end
      ST_LMUL: begin
        neg_q <= acc_val[ACC_WIDTH-1];
      end
      ST_LDIV: begin
        if (div_done) begin
          // First maximum wins: later classes replace it only when larger.
          if (cnt == '0 || logit_new > mx) begin
            mx   <= logit_new;
            best <= idx;
          end
          cnt <= last_cls ? '0 : cnt + CNW'(1);
        end
      end
      ST_ET: begin
        big_q <= tprod[48:32] > 17'd16;
        nsh_q <= tprod[36:32];
        f_q   <= tprod[31:16];
        m     <= ONE_Q31;
        j_q   <= '0;
      end
      ST_EFRAC: begin
        if (j_q == 3'd0) begin
          lowf <= ONE_Q31 - 32'(f_q[7:0]) * 32'(LN2_Q31_STEP);
        end
        if (f_q[{1'b1, ~j_q}]) begin
          m <= mprod[62:31];
        end
        j_q <= j_q + 3'd1;
      end
      ST_ELOW: begin
        m <= mprod[62:31];
      end
      ST_ESUM: begin
        sum <= sum + 25'(term);
        cnt <= last_cls ? '0 : cnt + CNW'(1);
      end
      ST_CDIV: begin
        conf_q <= (|div_quot[DIV_NW-1:16]) ? 16'hFFFF : div_quot[15:0];
      end
      ST_FINISH: begin
        result.best_class <= 6'(best);
        result.confidence <= conf_q;
      end
      default: ;
    endcase
  end

  // The result strobe lasts one cycle and always follows the final state.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held longer than one cycle");
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_FINISH))
    else $error("done without finishing a classification");
  a_conf_nonzero: assert property (@(posedge clk) disable iff (rst)
    done |-> result.confidence != 16'd0)
    else $error("confidence of zero reported");
  a_sum_floor: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CSTART) |-> sum >= 25'd65536)
    else $error("softmax sum lost the term of the best class");
  a_pipe_drained: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!p1v && !p2v))
    else $error("accumulate pipe busy while idle");

endmodule

`default_nettype wire

### dv/tb_cosine_softmax_classifier_top.sv
`default_nettype none

module tb_cosine_softmax_classifier_top;
  import csc_pkg::*;

  // The table rows are preloaded over this many leading element positions,
  // and image elements only ever use these positions, so no unwritten entry
  // is ever read.
  localparam int VEC_SPAN = 8;
  localparam longint CYCLE_LIMIT = 64'd30000000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  request_t request = '0;
  logic     busy;
  logic     done;
  result_t  result;
  logic     cfg_write = 1'b0;
  logic     cfg_index = CFG_CLASS_COUNT;
  logic [7:0] cfg_data = '0;

  cosine_softmax_classifier_top dut (
    .clk(clk), .rst(rst), .start(start), .request(request),
    .busy(busy), .done(done), .result(result),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // A 2-unit clock period: one unit high, one unit low.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Local copy of the block's state, kept in step with every accepted request.
  shortint     emb_rows [64][1024];
  logic [47:0] dot_acc [64];
  logic [47:0] energy;
  logic [6:0]  num_classes_reg;
  logic [7:0]  scale_reg;

  result_t expected_labels[$];
  int      mismatch_count = 0;
  int      label_count = 0;
  int      request_count = 0;
  longint  cycle_count = 0;
  int      send_idle_pct = 0;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("MISMATCH at cycle %0d: %s", cycle_count, what);
  endtask

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 46;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // exp(-d) in Q1.16 for a logit gap d in Q.16, computed as a power of two
  // with the same table and truncation steps as the hardware.
  function automatic longint unsigned exp_gap(input longint unsigned d);
    longint unsigned t, n, f, m;
    longint unsigned frac_tab [8];
    frac_tab = '{1518500250, 1805811301, 1969251188, 2056437387,
                 2101467502, 2124350982, 2135885998, 2141676973};
    t = (d * 94548) >> 16;
    n = t >> 16;
    f = t & 64'hFFFF;
    m = 64'd2147483648;
    if (n > 16) return 0;
    for (int j = 0; j < 8; j++)
      if ((f >> (15 - j)) & 1) m = (m * frac_tab[j]) >> 31;
    m = (m * (64'd2147483648 - (f & 255) * 22713)) >> 31;
    return (m >> 15) >> n;
  endfunction

  // Scores the accumulated vector against the scored classes and clears the
  // accumulators, exactly as the block does on the last image element.
  function automatic result_t classify();
    result_t         r;
    int              used, best;
    longint unsigned norm, mag, q, total;
    longint          a, top;
    longint          logit [64];
    used = (num_classes_reg == 0) ? 1 : (num_classes_reg > 64) ? 64 : num_classes_reg;
    norm = int_sqrt(energy);
    best = 0;
    if (norm == 0) begin
      total = 65536 / used;
    end else begin
      for (int c = 0; c < used; c++) begin
        a = longint'(signed'(dot_acc[c]));
        mag = (a < 0) ? -a : a;
        q = (mag * scale_reg * 16) / norm;
        if (q > 64'h7FFFFFFF) q = 64'h7FFFFFFF;
        logit[c] = (a < 0) ? -longint'(q) : longint'(q);
      end
      top = logit[0];
      for (int c = 1; c < used; c++)
        if (logit[c] > top) begin
          top = logit[c];
          best = c;
        end
      q = 0;
      for (int c = 0; c < used; c++) q += exp_gap(top - logit[c]);
      total = (64'd1 << 32) / q;
    end
    if (total > 65535) total = 65535;
    r.best_class = best[5:0];
    r.confidence = total[15:0];
    for (int c = 0; c < 64; c++) dot_acc[c] = '0;
    energy = '0;
    return r;
  endfunction

  // Applies one accepted request to the local state.
  task automatic apply_request(input request_t r);
    longint v, p;
    v = longint'(r.value);
    if (!r.mode) begin
      emb_rows[r.class_index][r.element_index] = r.value;
      return;
    end
    for (int c = 0; c < 64; c++) begin
      p = v * longint'(emb_rows[c][r.element_index]);
      dot_acc[c] = dot_acc[c] + p[47:0];
    end
    p = v * v;
    energy = energy + p[47:0];
    if (r.last) expected_labels = {expected_labels, classify()};
  endtask

  // Sends one request, idling the given share of cycles first, and waits
  // until the block takes it. Start stays high afterwards until the next
  // falling edge, where the next request or a gap replaces it.
  task automatic send_request(input request_t r);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    request = r;
    @(posedge clk);
    while (busy) @(posedge clk);
    request_count++;
    apply_request(r);
  endtask

  // Waits until every expected result is in and the block has had time to
  // finish any element it may still be working on.
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (expected_labels.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] data);
    drain();
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    if (idx == CFG_CLASS_COUNT) num_classes_reg = data[6:0];
    else scale_reg = data;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2, 3: return 16'($urandom);
      4: return 16'sd0;
      default: return 16'($signed($urandom_range(8192)) - 4096);
    endcase
  endfunction

  function automatic request_t make_load(input int ci, input int ei, input logic signed [15:0] v);
    request_t r;
    r.mode = 1'b0;
    r.class_index = ci[5:0];
    r.element_index = ei[9:0];
    r.value = v;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic request_t make_elem(input int ei, input logic signed [15:0] v,
                                        input logic fin);
    request_t r;
    r.mode = 1'b1;
    r.class_index = 6'($urandom);
    r.element_index = ei[9:0];
    r.value = v;
    r.last = fin;
    return r;
  endfunction

  // Compares each result with the oldest expectation at the edge that takes it.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
    if (!rst && done) begin
      if (expected_labels.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        label_count++;
        if (result.best_class !== expected_labels[0].best_class)
          report_mismatch($sformatf("best_class got %0d want %0d",
                                    result.best_class, expected_labels[0].best_class));
        if (result.confidence !== expected_labels[0].confidence)
          report_mismatch($sformatf("confidence got %0d want %0d",
                                    result.confidence, expected_labels[0].confidence));
        void'(expected_labels.pop_front());
      end
    end
  end

  // Loads every class row over the leading element positions so image
  // elements there read only written entries.
  task automatic test_table_fill();
    for (int e = 0; e < VEC_SPAN; e++)
      for (int c = 0; c < 64; c++)
        send_request(make_load(c, e, pick_value()));
  endtask

  // Directed cases: field extremes, zero norm, a stray last on a load, the
  // top class and element positions, and several register settings.
  task automatic test_directed();
    send_request(make_load(63, 1023, 16'sh7FFF));
    send_request(make_load(0, 1023, 16'sh8000));
    // A last flag on a load must not produce a result.
    begin
      request_t r;
      r = make_load(5, 3, 16'sh1000);
      r.last = 1'b1;
      send_request(r);
    end
    // A vector of zeros has zero norm.
    send_request(make_elem(0, 16'sd0, 1'b1));
    send_request(make_elem(1, 16'sd0, 1'b0));
    send_request(make_elem(2, 16'sd0, 1'b1));
    write_reg(CFG_CLASS_COUNT, 8'd64);
    send_request(make_elem(0, 16'sd0, 1'b1));
    send_request(make_elem(7, 16'sh7FFF, 1'b1));
    send_request(make_elem(3, 16'sh8000, 1'b0));
    send_request(make_elem(4, 16'sh7FFF, 1'b1));
    write_reg(CFG_COS_SCALE, 8'd255);
    send_request(make_elem(5, 16'sh8000, 1'b1));
    send_request(make_elem(6, 16'sh0001, 1'b1));
    write_reg(CFG_COS_SCALE, 8'd0);
    send_request(make_elem(1, 16'sh4000, 1'b1));
    write_reg(CFG_CLASS_COUNT, 8'hFF);
    write_reg(CFG_COS_SCALE, 8'd1);
    send_request(make_elem(2, 16'shC000, 1'b1));
    write_reg(CFG_CLASS_COUNT, 8'd0);
    send_request(make_elem(6, 16'sh2000, 1'b1));
  endtask

  // Mostly well-formed vectors of one to four elements with random content,
  // mixed with table writes anywhere and loads carrying a stray last flag.
  task automatic test_random_traffic(input int budget);
    int sent, len;
    sent = 0;
    while (sent < budget) begin
      case ($urandom_range(9))
        0, 1: begin
          send_request(make_load($urandom_range(63), $urandom_range(1023), pick_value()));
          sent++;
        end
        2: begin
          request_t r;
          r = make_load($urandom_range(63), $urandom_range(1023), pick_value());
          r.last = 1'b1;
          send_request(r);
          sent++;
        end
        default: begin
          len = $urandom_range(1, 4);
          for (int k = 0; k < len; k++)
            send_request(make_elem($urandom_range(VEC_SPAN - 1), pick_value(), k == len - 1));
          sent += len;
        end
      endcase
    end
  endtask

  initial begin
    int counts [12];
    int idle_sets [3];
    counts = '{1, 0, 127, 3, 8, 2, 64, 16, 5, 1, 4, 7};
    idle_sets = '{33, 74, 0};
    for (int c = 0; c < 64; c++) dot_acc[c] = '0;
    energy = '0;
    num_classes_reg = 7'd1;
    scale_reg = 8'd100;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_table_fill();
    test_directed();
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = idle_sets[p];
      for (int k = 0; k < 12; k++) begin
        write_reg(CFG_CLASS_COUNT, 8'(counts[(k + 5 * p) % 12]));
        write_reg(CFG_COS_SCALE, (k % 4 == 0) ? 8'd255 : (k % 4 == 1) ? 8'd0
                                 : 8'($urandom_range(255)));
        // Wide class counts make each result slow, so they get fewer items.
        test_random_traffic(counts[(k + 5 * p) % 12] > 16 ? 20 : 44);
      end
    end
    drain();

    $display("Covered %0d requests and %0d classification results over zero norm,",
             request_count, label_count);
    $display("ignored loads, value extremes and class counts from 0 to 127.");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
